// File: hdl/clns_pkg.sv
// Shared types, codes and transfer tables for the character LCD nibble sequencer.
package clns_pkg;

  // Command codes
  localparam logic [2:0] CMD_INSTR  = 3'd0;
  localparam logic [2:0] CMD_CHAR   = 3'd1;
  localparam logic [2:0] CMD_INIT   = 3'd2;
  localparam logic [2:0] CMD_CURSOR = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_HOME   = 3'd5;

  // Configuration register indexes
  localparam logic REG_STROBE_HIGH = 1'b0;
  localparam logic REG_STROBE_LOW  = 1'b1;

  localparam logic [9:0] STROBE_RESET_US = 10'd700;

  // Step numbers
  localparam logic [3:0] STEP_BYTE_LAST = 4'd1;
  localparam logic [3:0] STEP_INIT_LAST = 4'd13;
  localparam logic [3:0] STEP_INIT_CMDS = 4'd4;

  // Fixed instruction bytes and waits
  localparam logic [7:0]  CURSOR_BASE   = 8'h80;
  localparam logic [7:0]  INSTR_CLEAR   = 8'h01;
  localparam logic [7:0]  INSTR_HOME    = 8'h02;
  localparam logic [3:0]  NIB_WAKE      = 4'h3;
  localparam logic [3:0]  NIB_4BIT      = 4'h2;
  localparam logic [14:0] POWER_UP_US   = 15'd20000;
  localparam logic [10:0] WAKE_US       = 11'd150;
  localparam logic [10:0] LONG_US       = 11'd2000;
  localparam logic [10:0] SHORT_US      = 11'd45;
  localparam logic [10:0] LAST_SETUP_US = 11'd120;

  // One nibble transfer on the display bus
  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [14:0] wait_before_us;
    logic [10:0] wait_after_us;
    logic        last;
  } xfer_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic known;
    logic last;
  } sts_t;

  // Setup instruction sent after the wake-up nibbles
  function automatic logic [7:0] init_instr(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h2C;
      3'd1:    b = 8'h0E;
      3'd2:    b = 8'h06;
      3'd3:    b = 8'h01;
      3'd4:    b = 8'h1C;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [10:0] init_wait(input logic [2:0] idx);
    logic [10:0] w;
    case (idx)
      3'd4:    w = LAST_SETUP_US;
      default: w = SHORT_US;
    endcase
    return w;
  endfunction

  // Build the transfer for one step of a command
  function automatic xfer_t build_xfer(input logic [2:0] cmd, input logic [7:0] byte_val,
                                       input logic [10:0] after_low, input logic [3:0] step);
    xfer_t      x;
    logic [2:0] idx;
    logic [3:0] rel;
    logic [7:0] b;
    rel = step - STEP_INIT_CMDS;
    idx = rel[3:1];
    b   = init_instr(idx);
    x   = '0;
    if (cmd == CMD_INIT) begin
      x.last = (step == STEP_INIT_LAST);
      case (step)
        4'd0: begin
          x.nibble         = NIB_WAKE;
          x.wait_before_us = POWER_UP_US;
          x.wait_after_us  = WAKE_US;
        end
        4'd1, 4'd2: begin
          x.nibble        = NIB_WAKE;
          x.wait_after_us = WAKE_US;
        end
        4'd3: begin
          x.nibble        = NIB_4BIT;
          x.wait_after_us = LONG_US;
        end
        default: begin
          if (rel[0]) begin
            x.nibble        = b[3:0];
            x.wait_after_us = init_wait(idx);
          end else begin
            x.nibble = b[7:4];
          end
        end
      endcase
    end else begin
      x.reg_select = (cmd == CMD_CHAR);
      x.last       = (step == STEP_BYTE_LAST);
      if (step[0]) begin
        x.nibble        = byte_val[3:0];
        x.wait_after_us = after_low;
      end else begin
        x.nibble = byte_val[7:4];
      end
    end
    return x;
  endfunction

endpackage

// File: hdl/clns_cmd_if.sv
// Command channel: one display command word per handshake.
interface clns_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] value;
  logic       row;
  logic [5:0] col;

  modport source(output valid, command, value, row, col, input ready);
  modport sink(input valid, command, value, row, col, output ready);
endinterface

// File: hdl/clns_xfer_if.sv
// Transfer channel: one nibble transfer word per handshake.
interface clns_xfer_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [14:0] wait_before_us;
  logic [10:0] wait_after_us;
  logic        last;

  modport source(output valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                 input ready);
  modport sink(input valid, reg_select, nibble, wait_before_us, wait_after_us, last,
               output ready);
endinterface

// File: hdl/clns_datapath.sv
// Datapath: latched command, step counter, transfer output register and strobe settings.
module clns_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          command,
  input  logic [7:0]          value,
  input  logic                row,
  input  logic [5:0]          col,
  input  clns_pkg::ctl_t      ctl,
  output clns_pkg::sts_t      sts,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [9:0]          cfg_data,
  output clns_pkg::xfer_t     xfer_word
);

  logic [2:0]      cmd_reg;
  logic [7:0]      byte_reg;
  logic [10:0]     after_reg;
  logic [3:0]      step;
  logic [9:0]      strobe_high;
  logic [9:0]      strobe_low;
  logic [7:0]      byte_next;
  logic [10:0]     after_next;
  logic [7:0]      cursor_addr;
  clns_pkg::xfer_t cur_xfer;

  // Decode the incoming command into its instruction byte and settle time
  assign cursor_addr = {1'b0, row, 6'b0} + {2'b0, col};

  always_comb begin
    byte_next  = value;
    after_next = '0;
    sts.known  = 1'b1;
    sts.last   = cur_xfer.last;
    case (command)
      clns_pkg::CMD_INSTR, clns_pkg::CMD_CHAR, clns_pkg::CMD_INIT: begin
        byte_next = value;
      end
      clns_pkg::CMD_CURSOR: begin
        byte_next = clns_pkg::CURSOR_BASE | cursor_addr;
      end
      clns_pkg::CMD_CLEAR: begin
        byte_next  = clns_pkg::INSTR_CLEAR;
        after_next = clns_pkg::SHORT_US;
      end
      clns_pkg::CMD_HOME: begin
        byte_next  = clns_pkg::INSTR_HOME;
        after_next = clns_pkg::LONG_US;
      end
      default: begin
        sts.known = 1'b0;
      end
    endcase
  end

  // Transfer for the current step
  assign cur_xfer = clns_pkg::build_xfer(cmd_reg, byte_reg, after_reg, step);

  // Latch the command and advance through its steps
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (ctl.load) begin
      step <= '0;
    end else if (ctl.emit) begin
      step <= cur_xfer.last ? 4'd0 : step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_reg   <= command;
      byte_reg  <= byte_next;
      after_reg <= after_next;
    end
    if (ctl.emit) begin
      xfer_word <= cur_xfer;
    end
  end

  // Hold the enable pulse timing settings
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_high <= clns_pkg::STROBE_RESET_US;
      strobe_low  <= clns_pkg::STROBE_RESET_US;
    end else if (cfg_wr_en) begin
      if (cfg_index == clns_pkg::REG_STROBE_HIGH) begin
        strobe_high <= cfg_data;
      end else begin
        strobe_low <= cfg_data;
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= clns_pkg::STEP_INIT_LAST)
    else $error("step counter past end of init sequence");

  a_init_ends: assert property (@(posedge clk) disable iff (rst)
    ctl.emit && cmd_reg == clns_pkg::CMD_INIT && step == clns_pkg::STEP_INIT_LAST |-> sts.last)
    else $error("init sequence did not end on its final step");

  a_byte_ends: assert property (@(posedge clk) disable iff (rst)
    ctl.emit && cmd_reg != clns_pkg::CMD_INIT && step == clns_pkg::STEP_BYTE_LAST |-> sts.last)
    else $error("byte write did not end after its low nibble");

  a_cfg_high: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en && cfg_index == clns_pkg::REG_STROBE_HIGH |=> strobe_high == $past(cfg_data))
    else $error("strobe high setting not written");

  a_cfg_low: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en && cfg_index == clns_pkg::REG_STROBE_LOW |=> strobe_low == $past(cfg_data))
    else $error("strobe low setting not written");

endmodule

// File: hdl/clns_ctrl.sv
// Controller: accepts a command word, then sequences its transfers into the output register.
module clns_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  clns_pkg::sts_t sts,
  output clns_pkg::ctl_t ctl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;
  logic   slot;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign slot     = !out_valid || out_ready;
  assign ctl.load = accept;
  assign ctl.emit = (state == ST_EMIT) && slot;

  // Advance between idle and emitting
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && sts.known) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot && sts.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the output word until taken
  always_comb begin
    out_valid_next = out_valid;
    if (ctl.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_unknown_drop: assert property (@(posedge clk) disable iff (rst)
    accept && !sts.known |=> state == ST_IDLE && !ctl.emit)
    else $error("unknown command started a sequence");

  a_known_starts: assert property (@(posedge clk) disable iff (rst)
    accept && sts.known |=> state == ST_EMIT)
    else $error("known command did not start a sequence");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    ctl.emit && sts.last |=> state == ST_IDLE && out_valid)
    else $error("final transfer did not return to idle");

  a_emit_fills: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> out_valid)
    else $error("emitted transfer lost");

endmodule

// File: hdl/char_lcd_nibble_sequencer_top.sv
// Top level of the character LCD 4-bit nibble sequencer.
// Each command word becomes a series of nibble transfer words, high nibble first: byte
// writes, set cursor, clear and home give two transfers, init gives fourteen, and unknown
// codes give none. The command is taken while the controller is idle, after which the
// controller loads one transfer per cycle into a single output register whenever that
// register is empty or being taken by the sink, and holds while the sink stalls. The
// next command is taken as soon as the last transfer of the previous one sits in the
// output register. The strobe timing registers are kept but do not enter the transfers.
module char_lcd_nibble_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  clns_cmd_if.sink    cmd,
  clns_xfer_if.source xfer,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);

  clns_pkg::ctl_t  ctl;
  clns_pkg::sts_t  sts;
  clns_pkg::xfer_t xfer_word;

  // Sequence control
  clns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (xfer.valid),
    .out_ready (xfer.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Command decode and transfer generation
  clns_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .command   (cmd.command),
    .value     (cmd.value),
    .row       (cmd.row),
    .col       (cmd.col),
    .ctl       (ctl),
    .sts       (sts),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .xfer_word (xfer_word)
  );

  // Drive the transfer payload
  assign xfer.reg_select     = xfer_word.reg_select;
  assign xfer.nibble         = xfer_word.nibble;
  assign xfer.wait_before_us = xfer_word.wait_before_us;
  assign xfer.wait_after_us  = xfer_word.wait_after_us;
  assign xfer.last           = xfer_word.last;

endmodule

// File: sim/lcd_xfer_checker.sv
// Transfer checker: expands each accepted command into the expected nibble words and compares.
module lcd_xfer_checker (
  input  logic       clk,
  input  logic       rst,
  clns_cmd_if        cmd,
  clns_xfer_if       xfer,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Setup instructions sent after the wake-up nibbles, with their settle times
  localparam logic [7:0]  SETUP_BYTES [5] = '{8'h2C, 8'h0E, 8'h06, 8'h01, 8'h1C};
  localparam logic [10:0] SETUP_WAITS [5] = '{11'd45, 11'd45, 11'd45, 11'd45, 11'd120};

  clns_pkg::xfer_t expected_xfers[$];

  // Strobe timing only shapes the enable pulse; it never reaches a transfer word
  logic [9:0] strobe_high_us;
  logic [9:0] strobe_low_us;

  function automatic void push_nibble(input logic rs, input logic [3:0] nib,
                                      input logic [14:0] lead_us, input logic [10:0] settle_us);
    clns_pkg::xfer_t x;
    x.reg_select     = rs;
    x.nibble         = nib;
    x.wait_before_us = lead_us;
    x.wait_after_us  = settle_us;
    x.last           = 1'b0;
    expected_xfers.push_back(x);
  endfunction

  // High nibble first, settle time only after the low one
  function automatic void push_byte(input logic rs, input logic [7:0] byte_val,
                                    input logic [10:0] settle_us);
    push_nibble(rs, byte_val[7:4], 15'd0, 11'd0);
    push_nibble(rs, byte_val[3:0], 15'd0, settle_us);
  endfunction

  function automatic void expand_command(input logic [2:0] code, input logic [7:0] byte_val,
                                         input logic row, input logic [5:0] col);
    int              start_len;
    clns_pkg::xfer_t tail;
    logic [7:0]      pos;
    start_len = expected_xfers.size();
    pos       = clns_pkg::CURSOR_BASE | (8'(col) + (row ? 8'h40 : 8'h00));
    case (code)
      clns_pkg::CMD_INSTR:  push_byte(1'b0, byte_val, 11'd0);
      clns_pkg::CMD_CHAR:   push_byte(1'b1, byte_val, 11'd0);
      clns_pkg::CMD_CURSOR: push_byte(1'b0, pos, 11'd0);
      clns_pkg::CMD_CLEAR:  push_byte(1'b0, clns_pkg::INSTR_CLEAR, clns_pkg::SHORT_US);
      clns_pkg::CMD_HOME:   push_byte(1'b0, clns_pkg::INSTR_HOME, clns_pkg::LONG_US);
      clns_pkg::CMD_INIT: begin
        push_nibble(1'b0, clns_pkg::NIB_WAKE, clns_pkg::POWER_UP_US, clns_pkg::WAKE_US);
        push_nibble(1'b0, clns_pkg::NIB_WAKE, 15'd0, clns_pkg::WAKE_US);
        push_nibble(1'b0, clns_pkg::NIB_WAKE, 15'd0, clns_pkg::WAKE_US);
        push_nibble(1'b0, clns_pkg::NIB_4BIT, 15'd0, clns_pkg::LONG_US);
        for (int i = 0; i < 5; i++) push_byte(1'b0, SETUP_BYTES[i], SETUP_WAITS[i]);
      end
      default: ;
    endcase
    // Flag the final word of this command
    if (expected_xfers.size() > start_len) begin
      tail      = expected_xfers.pop_back();
      tail.last = 1'b1;
      expected_xfers.push_back(tail);
    end
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    clns_pkg::xfer_t got;
    clns_pkg::xfer_t want;
    if (rst) begin
      expected_xfers.delete();
      strobe_high_us <= clns_pkg::STROBE_RESET_US;
      strobe_low_us  <= clns_pkg::STROBE_RESET_US;
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        if (cfg_index == clns_pkg::REG_STROBE_HIGH) strobe_high_us <= cfg_data;
        else strobe_low_us <= cfg_data;
      end
      if (cmd.valid && cmd.ready) expand_command(cmd.command, cmd.value, cmd.row, cmd.col);
      // Compare each accepted word with the oldest expectation
      if (xfer.valid && xfer.ready) begin
        got.reg_select     = xfer.reg_select;
        got.nibble         = xfer.nibble;
        got.wait_before_us = xfer.wait_before_us;
        got.wait_after_us  = xfer.wait_after_us;
        got.last           = xfer.last;
        if (expected_xfers.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: rs=%0d nib=%h wb=%0d wa=%0d last=%0d",
                     got.reg_select, got.nibble, got.wait_before_us, got.wait_after_us,
                     got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_xfers.pop_front();
          if (got.reg_select !== want.reg_select || got.nibble !== want.nibble ||
              got.wait_before_us !== want.wait_before_us ||
              got.wait_after_us !== want.wait_after_us || got.last !== want.last) begin
            if (fail_count < 10)
              $display("word mismatch: want rs=%0d nib=%h wb=%0d wa=%0d last=%0d, %s",
                       want.reg_select, want.nibble, want.wait_before_us,
                       want.wait_after_us, want.last,
                       $sformatf("got rs=%0d nib=%h wb=%0d wa=%0d last=%0d",
                                 got.reg_select, got.nibble, got.wait_before_us,
                                 got.wait_after_us, got.last));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_xfers.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top: drives commands, register writes and sink stalls, and reports the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the block must ignore
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [9:0] cfg_data;
  int         fail_count;
  int         pending;
  int         cycles;
  int         cmds_sent;

  clns_cmd_if  cmd_bus();
  clns_xfer_if xfer_bus();

  char_lcd_nibble_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_bus),
    .xfer      (xfer_bus),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcd_xfer_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_bus),
    .xfer       (xfer_bus),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bail out on a hang
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the sink at random, with quiet stretches
  initial begin
    int stall;
    int taken;
    taken = 0;
    xfer_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (((taken / 20) % 3) == 2) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        xfer_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      xfer_bus.ready <= 1'b1;
      do @(posedge clk); while (!xfer_bus.valid);
      taken++;
    end
  end

  // Hold a command word until taken; keep valid high when the next one follows at once
  task automatic send_command(input logic [2:0] code, input logic [7:0] byte_val,
                              input logic row, input logic [5:0] col);
    int gap;
    gap = (((cmds_sent / 15) % 3) == 1) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.command <= code;
    cmd_bus.value   <= byte_val;
    cmd_bus.row     <= row;
    cmd_bus.col     <= col;
    do @(posedge clk); while (!cmd_bus.ready);
    cmds_sent++;
  endtask

  // Drop valid and let the block drain until no expected transfer is pending
  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_strobes(input logic [9:0] high_us, input logic [9:0] low_us);
    cfg_wr_en <= 1'b1;
    cfg_index <= clns_pkg::REG_STROBE_HIGH;
    cfg_data  <= high_us;
    @(posedge clk);
    cfg_index <= clns_pkg::REG_STROBE_LOW;
    cfg_data  <= low_us;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly byte and cursor writes, some init, clear, home and ignored codes
  task automatic send_random_batch(input int count);
    int         known;
    int         pick;
    logic [2:0] code;
    logic [5:0] col;
    known = 0;
    while (known < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) code = clns_pkg::CMD_INSTR;
      else if (pick < 56) code = clns_pkg::CMD_CHAR;
      else if (pick < 76) code = clns_pkg::CMD_CURSOR;
      else if (pick < 84) code = clns_pkg::CMD_CLEAR;
      else if (pick < 90) code = clns_pkg::CMD_HOME;
      else if (pick < 95) code = clns_pkg::CMD_INIT;
      else code = ($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
      if (code <= clns_pkg::CMD_HOME) known++;
      col = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                        : 6'($urandom_range(0, 39));
      send_command(code, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), col);
    end
  endtask

  initial begin
    cmds_sent       = 0;
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= clns_pkg::REG_STROBE_HIGH;
    cfg_data        <= '0;
    cmd_bus.valid   <= 1'b0;
    cmd_bus.command <= clns_pkg::CMD_INSTR;
    cmd_bus.value   <= '0;
    cmd_bus.row     <= 1'b0;
    cmd_bus.col     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every command, far columns, ignored codes
    write_strobes(10'd1, 10'd1000);
    send_command(clns_pkg::CMD_INIT, 8'h00, 1'b0, 6'd0);
    send_command(clns_pkg::CMD_INSTR, 8'h00, 1'b0, 6'd0);
    send_command(clns_pkg::CMD_INSTR, 8'hFF, 1'b1, 6'd63);
    send_command(clns_pkg::CMD_INSTR, 8'hA5, 1'b0, 6'd0);
    send_command(clns_pkg::CMD_CHAR, 8'h00, 1'b0, 6'd0);
    send_command(clns_pkg::CMD_CHAR, 8'hFF, 1'b0, 6'd0);
    send_command(clns_pkg::CMD_CHAR, 8'h5A, 1'b1, 6'd21);
    send_command(clns_pkg::CMD_CURSOR, 8'hFF, 1'b0, 6'd0);
    send_command(clns_pkg::CMD_CURSOR, 8'h00, 1'b1, 6'd39);
    send_command(clns_pkg::CMD_CURSOR, 8'h00, 1'b0, 6'd63);
    send_command(clns_pkg::CMD_CURSOR, 8'h00, 1'b1, 6'd63);
    send_command(clns_pkg::CMD_CURSOR, 8'h00, 1'b1, 6'd0);
    send_command(clns_pkg::CMD_CLEAR, 8'hFF, 1'b1, 6'd63);
    send_command(clns_pkg::CMD_HOME, 8'h00, 1'b0, 6'd0);
    send_command(CMD_SPARE_LO, 8'h3C, 1'b1, 6'd5);
    send_command(CMD_SPARE_HI, 8'hC3, 1'b0, 6'd42);
    send_command(clns_pkg::CMD_CHAR, 8'h41, 1'b0, 6'd0);
    send_command(clns_pkg::CMD_INIT, 8'hFF, 1'b1, 6'd63);
    send_command(clns_pkg::CMD_HOME, 8'h00, 1'b0, 6'd0);
    send_command(clns_pkg::CMD_CLEAR, 8'h00, 1'b0, 6'd0);
    wait_idle();

    // Random phases under different strobe settings, extremes among them
    write_strobes(10'd1000, 10'd1);
    send_random_batch(40);
    wait_idle();
    write_strobes(10'($urandom_range(1, 1000)), 10'($urandom_range(1, 1000)));
    send_random_batch(40);
    wait_idle();
    write_strobes(10'd1000, 10'd1000);
    send_random_batch(40);
    wait_idle();
    write_strobes(10'd1, 10'd1);
    send_random_batch(40);
    wait_idle();
    write_strobes(10'($urandom_range(1, 1000)), 10'($urandom_range(1, 1000)));
    send_random_batch(40);
    wait_idle();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
